// ===== rtl/core/vun_pkg.sv =====
// shared constants for the vector normalisation block
`timescale 1ns / 1ps
package vun_pkg;
  localparam int MAX_LEN = 16;
  localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 6;
  localparam logic [DATA_W-1:0] ONE_Q30 = 32'h4000_0000;
endpackage

// ===== rtl/core/vun_ram.sv =====
// generic single-port ram with registered read
`timescale 1ns / 1ps
module vun_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule

// ===== rtl/core/vector_unit_normalize.sv =====
// top level: l2 normalisation of a vector held in an element ram
`timescale 1ns / 1ps
// usage
// - a request is taken at a rising edge with start high and busy low;
//   it carries one signed q16.16 element and last_element, which ends the vector
// - a stored element goes through ram write, square and saturating add;
//   an element beyond capacity is dropped and sets overflowed
// - the last request then runs the square root, two radicand bits per cycle
//   through one root/remainder register pair
// - results follow one per stored element, each shown for one cycle with strobe
//   high; each takes a ram read, an operand load and a restoring divider, or
//   only the ram read and operand load when the magnitude is zero
// - busy stays high from each accepted stored element until the block can take
//   the next request; it is already low in the cycle that shows the final result
// - the receiver cannot stall: strobe marks a result for exactly one cycle
// - rst (synchronous) clears the count, sum, overflow flag and sequencer; ram
//   contents are not cleared, only entries written for the current vector are read
module vector_unit_normalize (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [vun_pkg::DATA_W-1:0]  element_value,
  input  logic                        last_element,
  output logic                        strobe,
  output logic [vun_pkg::DATA_W-1:0]  unit_value,
  output logic [vun_pkg::DATA_W-1:0]  magnitude,
  output logic [vun_pkg::IDX_W-1:0]   element_index,
  output logic                        last_result,
  output logic                        overflowed
);
  import vun_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_LD   = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;

  logic [2:0]        state;
  logic [CNT_W-1:0]  count;
  logic [63:0]       sum;
  logic              ovf;
  logic              last_q;
  logic [31:0]       x_abs;
  logic [63:0]       prod;
  logic [ADDR_W-1:0] idx;
  logic [4:0]        step;

  // square root datapath
  logic [63:0] rad;
  logic [33:0] rem;
  logic [31:0] root;
  logic [31:0] mag;

  // divider datapath
  logic [31:0] dr;
  logic [30:0] dlo;
  logic [30:0] quo;
  logic        neg;

  logic [DATA_W-1:0] rdata;
  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_addr;

  logic [31:0] in_abs;
  logic [64:0] sum_wide;
  logic [63:0] sum_next;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic [32:0] dtrial;
  logic        dbit;
  logic [30:0] quo_next;
  logic [31:0] rd_abs;
  logic        final_elem;

  assign busy = (state != S_IDLE);

  assign in_abs   = element_value[31] ? (32'd0 - element_value) : element_value;
  assign rd_abs   = rdata[31] ? (32'd0 - rdata) : rdata;
  assign sum_wide = {1'b0, sum} + {1'b0, prod};
  // saturate the sum of squares at all ones
  assign sum_next = sum_wide[64] ? {64{1'b1}} : sum_wide[63:0];

  // one root bit per cycle from two radicand bits
  assign rem_sh = {rem, rad[63:62]};
  assign trial  = {2'b00, root, 2'b01};

  // restoring divide step, remainder stays below the magnitude
  assign dtrial   = {dr, dlo[30]};
  assign dbit     = (dtrial >= {1'b0, mag});
  assign quo_next = {quo[29:0], dbit};

  assign final_elem = ({1'b0, idx} + {{(CNT_W-1){1'b0}}, 1'b1}) == count;

  assign ram_we   = (state == S_IDLE) && start && (count < CNT_W'(MAX_LEN));
  assign ram_re   = (state == S_RD);
  assign ram_addr = (state == S_IDLE) ? count[ADDR_W-1:0] : idx;

  vun_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (element_value),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      sum    <= '0;
      ovf    <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            last_q <= last_element;
            if (count < CNT_W'(MAX_LEN)) begin
              x_abs <= in_abs;
              count <= count + 1'b1;
              state <= S_MUL;
            end else begin
              // dropped element, a dropped last still ends the vector
              ovf <= 1'b1;
              if (last_element) begin
                rad   <= sum;
                rem   <= '0;
                root  <= '0;
                step  <= '0;
                state <= S_SQRT;
              end
            end
          end
        end
        S_MUL: begin
          prod  <= x_abs * x_abs;
          state <= S_ACC;
        end
        S_ACC: begin
          sum <= sum_next;
          if (last_q) begin
            rad   <= sum_next;
            rem   <= '0;
            root  <= '0;
            step  <= '0;
            state <= S_SQRT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SQRT: begin
          rad <= {rad[61:0], 2'b00};
          if (rem_sh >= trial) begin
            rem  <= 34'(rem_sh - trial);
            root <= {root[30:0], 1'b1};
            if (step == 5'd31) mag <= {root[30:0], 1'b1};
          end else begin
            rem  <= rem_sh[33:0];
            root <= {root[30:0], 1'b0};
            if (step == 5'd31) mag <= {root[30:0], 1'b0};
          end
          step <= step + 1'b1;
          if (step == 5'd31) begin
            idx   <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_LD;
        end
        S_LD: begin
          neg <= rdata[31];
          if (mag == '0) begin
            // zero magnitude: 1.0 for the first element, zero elsewhere
            unit_value    <= (idx == '0) ? ONE_Q30 : '0;
            magnitude     <= mag;
            element_index <= IDX_W'(idx);
            last_result   <= final_elem;
            overflowed    <= ovf;
            strobe        <= 1'b1;
            if (final_elem) begin
              count <= '0;
              sum   <= '0;
              ovf   <= 1'b0;
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_RD;
            end
          end else begin
            // dividend is abs << 30, upper part already below the magnitude
            dr    <= {1'b0, rd_abs[31:1]};
            dlo   <= {rd_abs[0], 30'd0};
            quo   <= '0;
            step  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          dr   <= dbit ? 32'(dtrial - {1'b0, mag}) : dtrial[31:0];
          dlo  <= {dlo[29:0], 1'b0};
          quo  <= quo_next;
          step <= step + 1'b1;
          if (step == 5'd30) begin
            unit_value    <= neg ? (32'd0 - {1'b0, quo_next}) : {1'b0, quo_next};
            magnitude     <= mag;
            element_index <= IDX_W'(idx);
            last_result   <= final_elem;
            overflowed    <= ovf;
            strobe        <= 1'b1;
            if (final_elem) begin
              count <= '0;
              sum   <= '0;
              ovf   <= 1'b0;
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // final result returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last_result |-> !busy)
    else $error("block still busy after final result");

  // results are never back to back, each needs a ram read first
  a_spaced: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("results on consecutive cycles");

  // normalised value stays within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ($signed(unit_value) <= $signed(ONE_Q30)) &&
               ($signed(unit_value) >= -$signed(ONE_Q30)))
    else $error("unit value out of range");
endmodule

// ===== bench/testbench.sv =====
// testbench for the vector normalisation block: self-checking with directed and random stimulus
`timescale 1ns / 1ps
module testbench;
  import vun_pkg::*;

  localparam int LIMIT_NS = 40_000_000;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
  } element_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] unit;
    logic [DATA_W-1:0] mag;
    logic [IDX_W-1:0]  idx;
    logic              last;
    logic              ovf;
  } unit_res_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [DATA_W-1:0] element_value = '0;
  logic              last_element = 1'b0;
  logic              busy, strobe, last_result, overflowed;
  logic [DATA_W-1:0] unit_value, magnitude;
  logic [IDX_W-1:0]  element_index;

  vector_unit_normalize i_dut (
    .clk, .rst, .start, .busy, .element_value, .last_element,
    .strobe, .unit_value, .magnitude, .element_index, .last_result, .overflowed
  );

  // pending requests, and the results the vector model says must come out
  element_req_t pending_reqs[$];
  unit_res_t    expected_units[$];

  // own model of the block state
  logic [DATA_W-1:0] vec_store[MAX_LEN];
  int                vec_count = 0;
  logic [63:0]       sum_sq = '0;
  logic              dropped = 1'b0;

  int errors = 0;
  int vectors_done = 0;
  int results_seen = 0;
  int sent = 0;

  function automatic logic [31:0] abs_val(logic [31:0] x);
    return x[31] ? (32'd0 - x) : x;
  endfunction

  function automatic logic [31:0] isqrt64(logic [63:0] v);
    logic [63:0] rem, root, bitv;
    rem = v;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[31:0];
  endfunction

  // absorb one accepted element; on the last one, queue the whole output run
  task automatic normalise_element(element_req_t r);
    logic [63:0] sq, q;
    logic [31:0] mag, u;
    unit_res_t   res;
    if (vec_count < MAX_LEN) begin
      sq = {32'd0, abs_val(r.value)} * {32'd0, abs_val(r.value)};
      vec_store[vec_count] = r.value;
      vec_count++;
      sum_sq = (sum_sq > ~64'd0 - sq) ? ~64'd0 : sum_sq + sq;
    end else begin
      dropped = 1'b1;
    end
    if (r.last) begin
      mag = isqrt64(sum_sq);
      for (int i = 0; i < vec_count; i++) begin
        if (mag == 0) begin
          u = (i == 0) ? ONE_Q30 : '0;
        end else begin
          q = ({32'd0, abs_val(vec_store[i])} << 30) / {32'd0, mag};
          u = vec_store[i][31] ? (32'd0 - q[31:0]) : q[31:0];
        end
        res.unit = u;
        res.mag  = mag;
        res.idx  = i[IDX_W-1:0];
        res.last = (i + 1 == vec_count);
        res.ovf  = dropped;
        expected_units.push_back(res);
      end
      vec_count = 0;
      sum_sq = '0;
      dropped = 1'b0;
      vectors_done++;
    end
  endtask

  function automatic logic [31:0] rand_element(int kind);
    case (kind)
      0: return $urandom();
      1: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
      2: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'd0;
    endcase
  endfunction

  task automatic add_vector(int len, int kind);
    element_req_t r;
    for (int i = 0; i < len; i++) begin
      r.value = rand_element(kind);
      r.last  = (i == len - 1);
      pending_reqs.push_back(r);
    end
  endtask

  task automatic add_req(logic [31:0] v, logic l);
    element_req_t r;
    r.value = v;
    r.last  = l;
    pending_reqs.push_back(r);
  endtask

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    // directed: extremes, zero vector, single element, saturation, overflow
    add_req(32'h7FFF_FFFF, 1'b1);
    add_req(32'h8000_0000, 1'b1);
    add_req(32'h0000_0000, 1'b0);
    add_req(32'h0000_0000, 1'b1);            // zero magnitude
    add_req(32'h0001_0000, 1'b0);
    add_req(32'hFFFF_0000, 1'b1);
    add_req(32'h0000_0001, 1'b1);            // tiny magnitude
    for (int i = 0; i < 5; i++) add_req(32'h8000_0000, i == 4); // saturating sum
    for (int i = 0; i < 18; i++) add_req(32'hA5A5_5A5A ^ i, i == 17); // beyond capacity
    // random vectors: mostly in capacity, some over it
    while (pending_reqs.size() < 210) begin
      case ($urandom_range(0, 9))
        0:       add_vector($urandom_range(MAX_LEN + 1, MAX_LEN + 4), $urandom_range(0, 3));
        1:       add_vector(MAX_LEN, $urandom_range(0, 2));
        default: add_vector($urandom_range(1, 6), $urandom_range(0, 3));
      endcase
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // driver: bursts of requests with random gaps, inputs change on the falling edge
  int burst_left = 0;
  int gap_left = 0;
  logic busy_at_edge = 1'b0;
  always @(negedge clk) begin
    if (!rst) begin
      // a request still held by busy stays on the ports
      if (!(start && busy_at_edge)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          element_value <= pending_reqs[0].value;
          last_element  <= pending_reqs[0].last;
          start         <= 1'b1;
          void'(pending_reqs.pop_front());
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: accepted requests feed the model, results are checked in order
  always @(posedge clk) begin
    busy_at_edge <= busy;
    if (!rst) begin
      if (start && !busy) begin
        normalise_element('{value: element_value, last: last_element});
        sent++;
      end
      if (strobe) begin
        results_seen++;
        if (expected_units.size() == 0) begin
          $display("%0t: result with none expected: unit %h mag %h idx %0d",
                   $time, unit_value, magnitude, element_index);
          errors++;
        end else begin
          unit_res_t e;
          e = expected_units.pop_front();
          if (unit_value !== e.unit) begin
            $display("%0t: unit_value expected %h got %h", $time, e.unit, unit_value);
            errors++;
          end
          if (magnitude !== e.mag) begin
            $display("%0t: magnitude expected %h got %h", $time, e.mag, magnitude);
            errors++;
          end
          if (element_index !== e.idx) begin
            $display("%0t: element_index expected %0d got %0d", $time, e.idx, element_index);
            errors++;
          end
          if (last_result !== e.last) begin
            $display("%0t: last_result expected %b got %b", $time, e.last, last_result);
            errors++;
          end
          if (overflowed !== e.ovf) begin
            $display("%0t: overflowed expected %b got %b", $time, e.ovf, overflowed);
            errors++;
          end
        end
      end
    end
  end

  // end of run: all requests taken, all results in, then a short drain
  initial begin
    wait (!rst);
    wait (pending_reqs.size() == 0 && !start);
    wait (expected_units.size() == 0);
    repeat (200) @(posedge clk);
    $display("%0d requests, %0d vectors, %0d results checked", sent, vectors_done, results_seen);
    if (errors == 0 && expected_units.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout");
    $display("CHECK FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/vun_pkg.sv
rtl/core/vun_ram.sv
rtl/core/vector_unit_normalize.sv
bench/testbench.sv
